### rtl/core/pqs_pkg.sv
package pqs_pkg;
  localparam logic [1:0] MODE_CODEBOOK = 2'd0;
  localparam logic [1:0] MODE_QUERY    = 2'd1;
  localparam logic [1:0] MODE_ENTRY    = 2'd2;
  localparam logic [1:0] MODE_FINISH   = 2'd3;

  localparam logic REG_METRIC       = 1'b0;
  localparam logic REG_RESULT_COUNT = 1'b1;

  localparam int unsigned ScoreW = 40;
  localparam int unsigned IdW    = 64;
  localparam int unsigned ValW   = 16;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  subspace;
    logic [7:0]  centroid_index;
    logic [1:0]  dim_index;
    logic signed [15:0] component_value;
    logic [63:0] packed_codes;
    logic [63:0] entry_id;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        result_id;
    logic signed [39:0] score;
    logic               empty_slot;
    logic               last;
  } out_item_t;
endpackage

### rtl/core/pqs_if.sv
interface pqs_in_if;
  logic valid;
  logic ready;
  pqs_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pqs_out_if;
  logic valid;
  logic ready;
  pqs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/pqs_ram.sv
module pqs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### rtl/core/pq_adc_topk_search.sv
// Product-quantization search with a sorted best-k list.
// Channels: in_if (sink) takes items; mode selects codebook load, query load,
// database entry or finish. out_if (source) gives ranked results on finish.
// Config port: cfg_we_i, cfg_idx_i, cfg_data_i; register 0 metric, 1 k.
// A database entry holds the input off while one codebook and query word
// pair is read per cycle from the memories and fed to one multiplier, the
// read, product and accumulator registers drain, S_SAT saturates the sum
// and S_INS makes the best-list insert.
// Finish gives k results, one per cycle the receiver takes, then clears the
// list; padding slots have id all ones, score 0 and empty_slot set.
// The result register holds while out_if.ready is low; no input is taken
// until all results of a finish are transferred.
// Reset empties the list and sets metric 0, k 10; stores are undefined
// until written.
module pq_adc_topk_search #(
  parameter int unsigned SUBSPACES = 8,
  parameter int unsigned SUB_DIM   = 4,
  parameter int unsigned CENTROIDS = 256,
  parameter int unsigned TOPK_MAX  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  pqs_in_if.sink      in_if,
  pqs_out_if.source   out_if
);
  localparam int unsigned SubW  = (SUBSPACES > 1) ? $clog2(SUBSPACES) : 1;
  localparam int unsigned DimW  = (SUB_DIM > 1) ? $clog2(SUB_DIM) : 1;
  localparam int unsigned CenW  = $clog2(CENTROIDS);
  localparam int unsigned QDep  = SUBSPACES * SUB_DIM;
  localparam int unsigned QAW   = (QDep > 1) ? $clog2(QDep) : 1;
  localparam int unsigned CbDep = SUBSPACES * CENTROIDS * SUB_DIM;
  localparam int unsigned CbAW  = $clog2(CbDep);
  localparam int unsigned KW    = $clog2(TOPK_MAX + 1);
  localparam int unsigned KIW   = (TOPK_MAX > 1) ? $clog2(TOPK_MAX) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_SAT  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic       metric_q;
  logic [4:0] rcount_q;
  logic [63:0] codes_q, id_q;
  logic [QAW-1:0] step_q;       // word index being issued
  logic [SubW-1:0] sc_sub_q;
  logic [DimW-1:0] sc_dim_q;
  logic        rd_valid_q;      // memory output valid this cycle
  logic        mul_valid_q;
  logic        acc_done_q;      // all words issued
  logic signed [33:0] prod_q;
  logic signed [63:0] acc_q;
  logic signed [39:0] sc_q;
  logic [KW-1:0] count_q;
  logic [KW-1:0] emit_q, k_q;
  logic signed [39:0] best_sc_q [TOPK_MAX];
  logic [63:0]        best_id_q [TOPK_MAX];
  pqs_pkg::out_item_t out_q;
  logic out_valid_q;

  logic in_xfer;
  assign in_xfer = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE);

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= 1'b0;
      rcount_q <= 5'd10;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pqs_pkg::REG_METRIC) metric_q <= cfg_data_i[0];
      else rcount_q <= cfg_data_i;
    end
  end

  // address decode for loads
  logic [SubW-1:0] ld_sub;
  logic [DimW-1:0] ld_dim;
  logic [CenW-1:0] ld_cen;
  logic ld_ok_q, ld_ok_cb;
  assign ld_sub = SubW'(in_if.data.subspace);
  assign ld_dim = DimW'(in_if.data.dim_index);
  assign ld_cen = CenW'(in_if.data.centroid_index);
  assign ld_ok_q = (32'(in_if.data.subspace) < SUBSPACES) &&
                   (32'(in_if.data.dim_index) < SUB_DIM);
  assign ld_ok_cb = ld_ok_q && (32'(in_if.data.centroid_index) < CENTROIDS);

  // scan addressing
  logic [7:0]      code_raw;
  logic [CenW-1:0] sc_cen;
  assign code_raw = codes_q[8*sc_sub_q +: 8];
  assign sc_cen = (32'(code_raw) >= CENTROIDS) ? CenW'(CENTROIDS - 1) : CenW'(code_raw);

  logic [CbAW-1:0] cb_waddr, cb_raddr;
  logic [QAW-1:0]  q_waddr;
  assign cb_waddr = CbAW'((32'(ld_sub) * CENTROIDS + 32'(ld_cen)) * SUB_DIM + 32'(ld_dim));
  assign cb_raddr = CbAW'((32'(sc_sub_q) * CENTROIDS + 32'(sc_cen)) * SUB_DIM
                          + 32'(sc_dim_q));
  assign q_waddr  = QAW'(32'(ld_sub) * SUB_DIM + 32'(ld_dim));

  logic [15:0] cb_rdata, q_rdata;
  logic cb_we, q_we;
  assign cb_we = in_xfer && (in_if.data.mode == pqs_pkg::MODE_CODEBOOK) && ld_ok_cb;
  assign q_we  = in_xfer && (in_if.data.mode == pqs_pkg::MODE_QUERY) && ld_ok_q;

  pqs_ram #(.Width(16), .Depth(CbDep)) u_cb (
    .clk_i, .we_i(cb_we), .waddr_i(cb_waddr), .wdata_i(in_if.data.component_value),
    .raddr_i(cb_raddr), .rdata_o(cb_rdata)
  );
  pqs_ram #(.Width(16), .Depth(QDep)) u_q (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(in_if.data.component_value),
    .raddr_i(step_q), .rdata_o(q_rdata)
  );

  logic signed [16:0] diff;
  logic signed [33:0] prod_d;
  assign diff = 17'(signed'(q_rdata)) - 17'(signed'(cb_rdata));
  assign prod_d = metric_q ? 34'(signed'(q_rdata) * signed'(cb_rdata)) : 34'(diff * diff);

  logic issue_last;
  assign issue_last = (32'(step_q) == QDep - 1);

  // insertion position
  logic [TOPK_MAX-1:0] better;
  logic [KW-1:0] pos;
  always_comb begin
    logic scan_end;
    pos = count_q;
    scan_end = 1'b0;
    for (int i = 0; i < TOPK_MAX; i++) begin
      better[i] = metric_q ? (sc_q > best_sc_q[i]) : (sc_q < best_sc_q[i]);
    end
    for (int i = TOPK_MAX - 1; i >= 0; i--) begin
      if (KW'(i) < count_q && !scan_end) begin
        if (better[i]) pos = KW'(i);
        else scan_end = 1'b1;
      end
    end
  end

  logic [4:0] kc;
  assign kc = (rcount_q == 5'd0) ? 5'd1 :
              (32'(rcount_q) > TOPK_MAX) ? 5'(TOPK_MAX) : rcount_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_xfer) begin
        if (in_if.data.mode == pqs_pkg::MODE_ENTRY) state_d = S_ACC;
        else if (in_if.data.mode == pqs_pkg::MODE_FINISH) state_d = S_EMIT;
      end
      S_ACC:  if (!rd_valid_q && !mul_valid_q && step_q == '0 && acc_done_q) state_d = S_SAT;
      S_SAT:  state_d = S_INS;
      S_INS:  state_d = S_IDLE;
      S_EMIT: if (out_valid_q && out_if.ready && emit_q == k_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic out_take;
  assign out_take = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      sc_sub_q    <= '0;
      sc_dim_q    <= '0;
      rd_valid_q  <= 1'b0;
      mul_valid_q <= 1'b0;
      acc_done_q  <= 1'b0;
      count_q     <= '0;
      emit_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_valid_q  <= (state_q == S_ACC) && !acc_done_q;
      mul_valid_q <= rd_valid_q;
      if (state_q == S_IDLE && in_xfer) begin
        step_q <= '0;
        sc_sub_q <= '0;
        sc_dim_q <= '0;
        acc_done_q <= 1'b0;
        emit_q <= '0;
        k_q <= KW'(kc);
      end else if (state_q == S_ACC && !acc_done_q) begin
        if (issue_last) begin
          acc_done_q <= 1'b1;
          step_q <= '0;
          sc_sub_q <= '0;
          sc_dim_q <= '0;
        end else begin
          step_q <= step_q + 1'b1;
          if (sc_dim_q == DimW'(SUB_DIM - 1)) begin
            sc_dim_q <= '0;
            sc_sub_q <= sc_sub_q + 1'b1;
          end else begin
            sc_dim_q <= sc_dim_q + 1'b1;
          end
        end
      end
      if (state_q == S_INS && 32'(pos) < TOPK_MAX && 32'(count_q) < TOPK_MAX) begin
        count_q <= count_q + 1'b1;
      end
      if (state_q == S_EMIT) begin
        if (out_take) begin
          if (emit_q != k_q) begin
            out_valid_q <= 1'b1;
            emit_q <= emit_q + 1'b1;
          end else begin
            out_valid_q <= 1'b0;
          end
        end
        if (state_d == S_IDLE) count_q <= '0;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_xfer) begin
      codes_q <= in_if.data.packed_codes;
      id_q    <= in_if.data.entry_id;
      acc_q   <= '0;
    end
    if (rd_valid_q) prod_q <= prod_d;
    if (mul_valid_q) acc_q <= acc_q + 64'(prod_q);
    if (state_q == S_SAT) begin
      if (acc_q > 64'sd549755813887) sc_q <= 40'sh7FFFFFFFFF;
      else if (acc_q < -64'sd549755813888) sc_q <= 40'sh8000000000;
      else sc_q <= 40'(acc_q);
    end
    if (state_q == S_INS && 32'(pos) < TOPK_MAX) begin
      for (int i = TOPK_MAX - 1; i > 0; i--) begin
        if (KW'(i) > pos && KW'(i) <= count_q) begin
          best_sc_q[i] <= best_sc_q[i-1];
          best_id_q[i] <= best_id_q[i-1];
        end
      end
      best_sc_q[KIW'(pos)] <= sc_q;
      best_id_q[KIW'(pos)] <= id_q;
    end
    if (state_q == S_EMIT && out_take && emit_q != k_q) begin
      if (emit_q < count_q) begin
        out_q.result_id  <= best_id_q[KIW'(emit_q)];
        out_q.score      <= best_sc_q[KIW'(emit_q)];
        out_q.empty_slot <= 1'b0;
      end else begin
        out_q.result_id  <= '1;
        out_q.score      <= '0;
        out_q.empty_slot <= 1'b1;
      end
      out_q.last <= (emit_q + 1'b1 == k_q);
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;
endmodule

### rtl/core/pqs_checker.sv
module pqs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input pqs_pkg::out_item_t out_data_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i)) else $error("out hold");
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input during emit");
  a_empty_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.empty_slot |->
      out_data_i.score == '0 && out_data_i.result_id == '1)
    else $error("empty slot payload");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_data_i.last |=> !out_valid_i) else $error("after last");
endmodule

bind pq_adc_topk_search pqs_checker u_pqs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .out_data_i(out_if.data)
);

### dv/pqs_search_checker.sv
module pqs_search_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [4:0] cfg_data_i,
  pqs_in_if          in_ch,
  pqs_out_if         out_ch,
  output int         pending_o,
  output int         errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSUB = 8;
  localparam int NDIM = 4;
  localparam int NCEN = 256;
  localparam int KMAX = 16;
  localparam longint SAT_HI = 64'sd549755813887;
  localparam longint SAT_LO = -64'sd549755813888;

  logic signed [15:0] codebook_mem [NSUB*NCEN*NDIM];
  logic signed [15:0] query_mem [NSUB*NDIM];
  logic signed [39:0] kept_score [KMAX];
  logic [63:0]        kept_id [KMAX];
  int                 kept_cnt;
  logic               metric_q;
  logic [4:0]         k_q;
  pqs_pkg::out_item_t ranked_q [$];

  function automatic logic signed [39:0] entry_score(logic [63:0] codes);
    longint acc, qv, wv;
    int c;
    acc = 0;
    for (int s = 0; s < NSUB; s++) begin
      c = codes[8*s +: 8];
      for (int d = 0; d < NDIM; d++) begin
        qv = query_mem[s*NDIM + d];
        wv = codebook_mem[(s*NCEN + c)*NDIM + d];
        if (metric_q) acc += qv * wv;
        else acc += (qv - wv) * (qv - wv);
      end
    end
    if (acc > SAT_HI) acc = SAT_HI;
    if (acc < SAT_LO) acc = SAT_LO;
    return acc[39:0];
  endfunction

  function automatic bit beats(logic signed [39:0] a, logic signed [39:0] b);
    return metric_q ? (a > b) : (a < b);
  endfunction

  task automatic rank_insert(logic signed [39:0] sc, logic [63:0] id);
    int pos, i;
    pos = kept_cnt;
    while (pos > 0 && beats(sc, kept_score[pos-1])) pos--;
    if (pos < KMAX) begin
      i = (kept_cnt < KMAX) ? kept_cnt : KMAX - 1;
      for (; i > pos; i--) begin
        kept_score[i] = kept_score[i-1];
        kept_id[i] = kept_id[i-1];
      end
      kept_score[pos] = sc;
      kept_id[pos] = id;
      if (kept_cnt < KMAX) kept_cnt++;
    end
  endtask

  task automatic emit_ranked();
    int k;
    pqs_pkg::out_item_t r;
    k = k_q;
    if (k == 0) k = 1;
    if (k > KMAX) k = KMAX;
    for (int i = 0; i < k; i++) begin
      if (i < kept_cnt) begin
        r.result_id = kept_id[i];
        r.score = kept_score[i];
        r.empty_slot = 1'b0;
      end else begin
        r.result_id = '1;
        r.score = '0;
        r.empty_slot = 1'b1;
      end
      r.last = (i + 1 == k);
      ranked_q.insert(ranked_q.size(), r);
    end
    kept_cnt = 0;
  endtask

  initial errors_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    pqs_pkg::in_item_t it;
    pqs_pkg::out_item_t got, want;
    if (!rst_ni) begin
      metric_q = 1'b0;
      k_q = 5'd10;
      kept_cnt = 0;
      ranked_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == pqs_pkg::REG_METRIC) metric_q = cfg_data_i[0];
        else k_q = cfg_data_i;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (ranked_q.size() == 0) begin
          $error("unexpected result transfer id %h", got.result_id);
          errors_o++;
        end else begin
          want = ranked_q.pop_front();
          if (got.result_id !== want.result_id) begin
            $error("result_id: expected %h actual %h", want.result_id, got.result_id);
            errors_o++;
          end
          if (got.score !== want.score) begin
            $error("score: expected %0d actual %0d", want.score, got.score);
            errors_o++;
          end
          if (got.empty_slot !== want.empty_slot) begin
            $error("empty_slot: expected %b actual %b", want.empty_slot, got.empty_slot);
            errors_o++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %b actual %b", want.last, got.last);
            errors_o++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        it = in_ch.data;
        case (it.mode)
          pqs_pkg::MODE_CODEBOOK: codebook_mem[(it.subspace*NCEN + it.centroid_index)*NDIM
                                               + it.dim_index] = it.component_value;
          pqs_pkg::MODE_QUERY: query_mem[it.subspace*NDIM + it.dim_index] = it.component_value;
          pqs_pkg::MODE_ENTRY: rank_insert(entry_score(it.packed_codes), it.entry_id);
          default: emit_ranked();
        endcase
      end
    end
    pending_o = ranked_q.size();
  end
endmodule

### dv/pq_adc_topk_search_tb.sv
module pq_adc_topk_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic       cfg_idx;
  logic [4:0] cfg_data;
  int         pending;
  int         errors;
  bit         no_idle;
  bit         pressed;
  int         hold_cnt;
  int         quiet_cnt;
  bit         word_done [8][256][4];
  bit         cen_done [8][256];
  int         loaded_cen [8][$];
  logic [63:0] prev_codes;

  pqs_in_if  in_ch ();
  pqs_out_if out_ch ();

  pq_adc_topk_search dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  pqs_search_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ch.ready <= 1'b0;
      hold_cnt--;
    end else if (!pressed && pending > 4) begin
      pressed = 1'b1;
      hold_cnt = 300;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= 5000) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(pqs_pkg::in_item_t it);
    while (!no_idle && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic load_query(int s, int d, logic [15:0] v);
    pqs_pkg::in_item_t it;
    it = '0;
    it.mode = pqs_pkg::MODE_QUERY;
    it.subspace = s;
    it.dim_index = d;
    it.component_value = v;
    it.centroid_index = 8'($urandom);
    it.packed_codes = {$urandom, $urandom};
    it.entry_id = {$urandom, $urandom};
    send_item(it);
  endtask

  task automatic load_word(int s, int c, int d, logic [15:0] v);
    pqs_pkg::in_item_t it;
    it = '0;
    it.mode = pqs_pkg::MODE_CODEBOOK;
    it.subspace = s;
    it.centroid_index = c;
    it.dim_index = d;
    it.component_value = v;
    it.packed_codes = {$urandom, $urandom};
    it.entry_id = {$urandom, $urandom};
    send_item(it);
    word_done[s][c][d] = 1'b1;
    if (!cen_done[s][c] && word_done[s][c][0] && word_done[s][c][1] &&
        word_done[s][c][2] && word_done[s][c][3]) begin
      cen_done[s][c] = 1'b1;
      loaded_cen[s].insert(loaded_cen[s].size(), c);
    end
  endtask

  task automatic send_entry(logic [63:0] codes);
    pqs_pkg::in_item_t it;
    it = '0;
    it.mode = pqs_pkg::MODE_ENTRY;
    it.subspace = 3'($urandom);
    it.centroid_index = 8'($urandom);
    it.dim_index = 2'($urandom);
    it.component_value = 16'($urandom);
    it.packed_codes = codes;
    it.entry_id = ($urandom_range(9) == 0) ? 64'hffff_ffff_ffff_ffff : {$urandom, $urandom};
    send_item(it);
    prev_codes = codes;
  endtask

  function automatic logic [63:0] pick_codes();
    logic [63:0] codes;
    for (int s = 0; s < 8; s++)
      codes[8*s +: 8] = loaded_cen[s][$urandom_range(loaded_cen[s].size() - 1)];
    return codes;
  endfunction

  task automatic send_finish();
    pqs_pkg::in_item_t it;
    it = '0;
    it.mode = pqs_pkg::MODE_FINISH;
    it.packed_codes = {$urandom, $urandom};
    it.entry_id = {$urandom, $urandom};
    send_item(it);
  endtask

  task automatic write_reg(logic idx, logic [4:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic run_phase(int n, bit close_run);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) load_word($urandom_range(7), $urandom_range(255), $urandom_range(3),
                           pick_value());
      else if (r < 12) load_query($urandom_range(7), $urandom_range(3), pick_value());
      else if (r < 20) send_entry(prev_codes);
      else if (r < 90) send_entry(pick_codes());
      else send_finish();
    end
    if (close_run) send_finish();
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = pqs_pkg::REG_METRIC;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    no_idle = 1'b0;
    pressed = 1'b0;
    hold_cnt = 0;
    quiet_cnt = 0;
    prev_codes = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int s = 0; s < 8; s++)
      for (int d = 0; d < 4; d++)
        load_query(s, d, (s == 0 && d == 0) ? 16'h7fff :
                         (s == 0 && d == 1) ? 16'h8000 : pick_value());
    for (int s = 0; s < 8; s++)
      for (int d = 0; d < 4; d++) begin
        load_word(s, 0, d, (d == 0) ? 16'h8000 : pick_value());
        load_word(s, 255, d, (d == 0) ? 16'h7fff : pick_value());
      end

    send_finish();
    send_entry('0);
    send_entry('1);
    send_entry('1);
    send_entry(64'h00ff_00ff_00ff_00ff);
    send_entry(64'hff00_ff00_ff00_ff00);
    send_finish();
    settle();

    run_phase(5, 1'b1);
    write_reg(pqs_pkg::REG_METRIC, 5'd1);
    write_reg(pqs_pkg::REG_RESULT_COUNT, 5'd16);
    no_idle = 1'b1;
    run_phase(8, 1'b1);
    no_idle = 1'b0;
    write_reg(pqs_pkg::REG_METRIC, 5'd0);
    write_reg(pqs_pkg::REG_RESULT_COUNT, 5'd1);
    for (int i = 0; i < 4; i++) send_entry(pick_codes());
    settle();
    write_reg(pqs_pkg::REG_METRIC, 5'd1);
    write_reg(pqs_pkg::REG_RESULT_COUNT, 5'd0);
    run_phase(3, 1'b1);
    write_reg(pqs_pkg::REG_RESULT_COUNT, 5'd31);
    run_phase(3, 1'b1);
    write_reg(pqs_pkg::REG_METRIC, 5'd0);
    write_reg(pqs_pkg::REG_RESULT_COUNT, 5'd5);
    run_phase(3, 1'b1);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
